@@ rtl/core/wplt_pkg.sv @@
// Package for the windowed packet loss tracker: sequencer states and fixed constants.
`timescale 1ns / 1ps

package wplt_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	// Item kinds carried on tuser
	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	// Percent times 256
	localparam logic [14:0] PCT_SCALE = 15'd25600;

	localparam logic [31:0] TOTAL_MAX       = 32'hFFFF_FFFF;
	localparam logic [31:0] WINDOW_RESET_MS = 32'd300000;

	// Result field widths
	localparam int PCT_W = 15;
	localparam int CNT_W = 11;

endpackage

@@ rtl/core/windowed_packet_loss_tracker_unit.sv @@
// Windowed packet loss tracker: history ring, window walk and loss percentage divider.
// Record transaction: accepted while idle, s_tready stays high after it, no result.
// Query: the walk reads the n filled entries, then the scaling, the divide (DW = clog2(DEPTH+1) + 15)
//   and the result load follow, and an output stall can hold the result.
// s_tready is low for the whole query and returns with the result; one result is buffered.
// Async active-low reset clears counters and totals and loads a 300000 ms window; RAM kept.
`timescale 1ns / 1ps

module windowed_packet_loss_tracker_unit #(
	parameter int HISTORY_DEPTH = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // [0] ack_seen, [32:1] now_ms, [39:33] zero
	input  logic         s_tuser,   // [0] action
	// Result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [14:0] loss_percent_q8, [25:15] window_packets,
	                                // [36:26] window_lost, [68:37] sent_total,
	                                // [100:69] lost_total, [103:101] zero
	// Configuration
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata  // window_length_ms
);

	import wplt_pkg::*;

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int CW  = $clog2(HISTORY_DEPTH + 1);
	localparam int DW  = CW + PCT_W;
	localparam int DCW = $clog2(DW + 1);
	localparam logic [CW-1:0]  CNT_ONE  = CW'(1);
	localparam logic [AW-1:0]  SLOT_ONE = AW'(1);
	localparam logic [AW-1:0]  SLOT_LAST = AW'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0]  DEPTH_CNT = CW'(HISTORY_DEPTH);
	localparam logic [DCW-1:0] DIV_STEPS = DCW'(DW);

	state_t state_q, state_d;

	logic [31:0]   window_q;
	logic [AW-1:0] wr_slot_q;
	logic [CW-1:0] filled_q;
	logic [31:0]   sent_q;
	logic [31:0]   lost_q;

	// Query working registers
	logic [31:0]   now_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] rd_idx_q;
	logic          rd_vld_s1;
	logic [CW-1:0] pkts_q;
	logic [CW-1:0] wlost_q;
	logic [DW-1:0] dvd_q;
	logic [CW-1:0] rem_q;
	logic [PCT_W-1:0] quo_q;
	logic [DCW-1:0] dcnt_q;

	// Result register
	logic             m_valid_q;
	logic [PCT_W-1:0] r_pct_q;
	logic [CNT_W-1:0] r_pkts_q;
	logic [CNT_W-1:0] r_lost_q;
	logic [31:0]      r_sent_q;
	logic [31:0]      r_ltot_q;

	logic        in_acc;
	logic        rec_acc;
	logic        qry_acc;
	logic        ack_in;
	logic [31:0] now_in;
	logic        ram_we;
	logic [32:0] ram_wdata;
	logic [32:0] ram_rdata;
	logic        issue;
	logic [31:0] age;
	logic        in_win;
	logic [CW:0] trial;
	logic        ge;
	logic [CW:0] trial_sub;
	logic        out_free;
	logic [CW+CNT_W-1:0] pkts_ext;
	logic [CW+CNT_W-1:0] lost_ext;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign rec_acc  = in_acc && (s_tuser == ACT_RECORD);
	assign qry_acc  = in_acc && (s_tuser == ACT_QUERY);
	assign ack_in   = s_tdata[0];
	assign now_in   = s_tdata[32:1];

	// History ring: time in [31:0], ack in [32]
	assign ram_we    = rec_acc;
	assign ram_wdata = {ack_in, now_in};

	wplt_ram #(
		.WIDTH (33),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_slot_q),
		.wdata (ram_wdata),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Walk: one read issued per cycle, read data evaluated from the registered RAM output
	assign issue  = (rd_idx_q != n_q);
	assign age    = now_q - ram_rdata[31:0];
	assign in_win = (age <= window_q);

	// Divider step
	assign trial     = {rem_q, dvd_q[DW-1]};
	assign ge        = (trial >= {1'b0, pkts_q});
	assign trial_sub = trial - {1'b0, pkts_q};

	assign out_free = !m_valid_q || m_tready;
	assign pkts_ext = {{CNT_W{1'b0}}, pkts_q};
	assign lost_ext = {{CNT_W{1'b0}}, wlost_q};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (qry_acc) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (!issue && !rd_vld_s1) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (dcnt_q == DIV_STEPS) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET_MS;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// Ring pointer, fill count and saturating totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			filled_q  <= '0;
			sent_q    <= '0;
			lost_q    <= '0;
		end else if (rec_acc) begin
			wr_slot_q <= (wr_slot_q == SLOT_LAST) ? '0 : wr_slot_q + SLOT_ONE;
			if (filled_q != DEPTH_CNT) begin
				filled_q <= filled_q + CNT_ONE;
			end
			if (sent_q != TOTAL_MAX) begin
				sent_q <= sent_q + 32'd1;
			end
			if (!ack_in && (lost_q != TOTAL_MAX)) begin
				lost_q <= lost_q + 32'd1;
			end
		end
	end

	// Walk control and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			dcnt_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rd_idx_q  <= '0;
					rd_vld_s1 <= 1'b0;
				end
				ST_WALK: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_ONE;
					end
					rd_vld_s1 <= issue;
				end
				ST_MUL: begin
					dcnt_q <= '0;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + DCW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Query datapath: window counts, scaling and restoring division
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				now_q   <= now_in;
				n_q     <= filled_q;
				pkts_q  <= '0;
				wlost_q <= '0;
			end
			ST_WALK: begin
				if (rd_vld_s1 && in_win) begin
					pkts_q <= pkts_q + CNT_ONE;
					if (!ram_rdata[32]) begin
						wlost_q <= wlost_q + CNT_ONE;
					end
				end
			end
			ST_MUL: begin
				dvd_q <= {{PCT_W{1'b0}}, wlost_q} * {{CW{1'b0}}, PCT_SCALE};
				rem_q <= '0;
				quo_q <= '0;
			end
			ST_DIV: begin
				if (dcnt_q != DIV_STEPS) begin
					rem_q <= ge ? trial_sub[CW-1:0] : trial[CW-1:0];
					quo_q <= {quo_q[PCT_W-2:0], ge};
					dvd_q <= {dvd_q[DW-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			r_pct_q  <= (pkts_q == '0) ? '0 : quo_q;
			r_pkts_q <= pkts_ext[CNT_W-1:0];
			r_lost_q <= lost_ext[CNT_W-1:0];
			r_sent_q <= sent_q;
			r_ltot_q <= lost_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, r_ltot_q, r_sent_q, r_lost_q, r_pkts_q, r_pct_q};

endmodule

@@ rtl/core/wplt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wplt_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
